// ===== hdl/ftp_pkg.sv =====
// Package for the fixed-timestep tick pacer.
// Holds operation and status codes, field widths, default settings and the
// state and result structs shared by the step logic and the top level.
package ftp_pkg;

  // Field widths
  localparam int TIME_W   = 64;
  localparam int PERIOD_W = 16;
  localparam int OP_W     = 2;
  localparam int LAG_W    = 6;
  localparam int STATUS_W = 2;
  localparam int TICK_W   = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELTA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY      = 1'd1;

  // Register reset values
  localparam logic [PERIOD_W-1:0] TARGET_DELTA_RESET = 16'd16;
  localparam logic                QUALITY_RESET      = 1'b1;

  // Default grant limit
  localparam int MAX_TICKS_DEFAULT = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_FAIL   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAILED     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAILED_NOW = 2'd2;

  // Lag limits
  localparam logic [LAG_W-1:0] LAG_FAIL_LIMIT = 6'd30;
  localparam logic [LAG_W-1:0] LAG_NOTICE_1   = 6'd20;
  localparam logic [LAG_W-1:0] LAG_NOTICE_2   = 6'd40;
  localparam logic [LAG_W-1:0] LAG_NOTICE_3   = 6'd60;

  // Pacer state
  typedef struct packed {
    logic [TIME_W-1:0] ticked_up_to;
    logic [TIME_W-1:0] last_advanced;
    logic [LAG_W-1:0]  lag_count;
    logic              failed;
  } state_t;

  // One result
  typedef struct packed {
    logic [TICK_W-1:0]   tick_count;
    logic [STATUS_W-1:0] status;
    logic                lag_notice;
  } result_t;

endpackage

// ===== hdl/ftp_step.sv =====
// Step logic of the fixed-timestep tick pacer: next state and result for one
// request, purely combinational.
// Depends on ftp_pkg.
module ftp_step #(
  parameter int MAX_TICKS_PER_UPDATE = ftp_pkg::MAX_TICKS_DEFAULT
) (
  input  logic [ftp_pkg::OP_W-1:0]     op,
  input  logic [ftp_pkg::TIME_W-1:0]   now,
  input  logic [ftp_pkg::PERIOD_W-1:0] target_delta_ms,
  input  logic                         quality_checks,
  input  ftp_pkg::state_t              state,
  output ftp_pkg::state_t              state_next,
  output ftp_pkg::result_t             result
);

  localparam int TW = $clog2(MAX_TICKS_PER_UPDATE + 1);
  localparam int MW = ftp_pkg::PERIOD_W + $clog2(MAX_TICKS_PER_UPDATE + 1);

  logic [ftp_pkg::PERIOD_W-1:0] period;
  logic [ftp_pkg::TIME_W-1:0]   since;
  logic [ftp_pkg::TIME_W-1:0]   ahead;
  logic [ftp_pkg::TIME_W-1:0]   behind;
  logic                         too_early;
  logic [TW-1:0]                ticks;
  logic [ftp_pkg::TIME_W-1:0]   cand [1:MAX_TICKS_PER_UPDATE];
  logic [ftp_pkg::LAG_W-1:0]    lag_inc;
  logic                         full_grant;

  // Zero period counts as one
  assign period = (target_delta_ms == '0) ? ftp_pkg::PERIOD_W'(1) : target_delta_ms;

  // Time since last advance, and tick mark relative to now
  assign since     = now - state.last_advanced;
  assign too_early = since[ftp_pkg::TIME_W-1] ||
                     (since < ftp_pkg::TIME_W'(period >> 1));
  assign ahead     = state.ticked_up_to - now;
  assign behind    = '0 - ahead;

  // Grant: one tick plus one per full period of lag, capped
  always_comb begin
    ticks = TW'(1);
    for (int k = 1; k < MAX_TICKS_PER_UPDATE; k++) begin
      if (behind >= ftp_pkg::TIME_W'(MW'(period) * MW'(k))) begin
        ticks = ticks + TW'(1);
      end
    end
  end

  // Candidate tick marks, one per possible grant
  always_comb begin
    for (int k = 1; k <= MAX_TICKS_PER_UPDATE; k++) begin
      cand[k] = state.ticked_up_to + ftp_pkg::TIME_W'(MW'(period) * MW'(k));
    end
  end

  assign full_grant = (ticks == TW'(MAX_TICKS_PER_UPDATE));
  assign lag_inc    = state.lag_count + ftp_pkg::LAG_W'(1);

  // Request decode
  always_comb begin
    state_next = state;
    result     = '0;
    case (op)
      ftp_pkg::OP_START: begin
        state_next.ticked_up_to  = now;
        state_next.last_advanced = now;
        state_next.lag_count     = '0;
        state_next.failed        = 1'b0;
      end
      ftp_pkg::OP_FAIL: begin
        state_next.failed = 1'b1;
      end
      ftp_pkg::OP_UPDATE: begin
        if (state.failed) begin
          result.status = ftp_pkg::STATUS_FAILED;
        end else if (!too_early && ahead[ftp_pkg::TIME_W-1]) begin
          if (full_grant && quality_checks) begin
            state_next.lag_count = lag_inc;
          end else begin
            state_next.lag_count = '0;
          end
          if (full_grant && quality_checks && (lag_inc > ftp_pkg::LAG_FAIL_LIMIT)) begin
            // sustained lag: fail, keep the time marks
            state_next.failed = 1'b1;
            result.status     = ftp_pkg::STATUS_FAILED_NOW;
          end else begin
            state_next.last_advanced = now;
            state_next.ticked_up_to  = cand[ticks];
            result.tick_count        = ftp_pkg::TICK_W'(ticks);
            result.lag_notice        = full_grant && quality_checks &&
                                       (lag_inc == '0 ||
                                        lag_inc == ftp_pkg::LAG_NOTICE_1 ||
                                        lag_inc == ftp_pkg::LAG_NOTICE_2 ||
                                        lag_inc == ftp_pkg::LAG_NOTICE_3);
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== hdl/fixed_timestep_tick_pacer.sv =====
// Top level of the fixed-timestep tick pacer: input register, state,
// configuration registers and result register around ftp_step.
// Depends on ftp_pkg and ftp_step.
//
// Usage: each request on the input channel (in_valid/in_ready) carries an
// operation (start, update, tick failure) and a signed millisecond time.
// Every request yields exactly one result on the output channel
// (out_valid/out_ready): ticks to run, status and a lag notice.
// Path: an accepted request enters the input register; its result is
// loaded into the result register once that is free (out_valid low or
// out_ready high) and is offered from then on.
// Throughput: one request per cycle while out_ready does not stall the
// output, set by the combinational step logic between the input register
// and the result register, which also updates the pacer state.
// Stall: while out_ready is low the result holds; the input register still
// takes one more request, after which in_ready drops until the result leaves.
// Reset: clears the time marks, lag count, failed flag and both valid flags;
// the tick period returns to 16 ms and quality checks turn on.
// Configuration: cfg_write with cfg_index 0 sets target_delta_ms, index 1
// sets quality_checks (bit 0 of cfg_data); write only while idle.
module fixed_timestep_tick_pacer #(
  parameter int MAX_TICKS_PER_UPDATE = ftp_pkg::MAX_TICKS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [ftp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ftp_pkg::PERIOD_W-1:0]        cfg_data,
  // requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ftp_pkg::OP_W-1:0]            operation,
  input  logic signed [ftp_pkg::TIME_W-1:0]   now_ms,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ftp_pkg::TICK_W-1:0]          tick_count,
  output logic [ftp_pkg::STATUS_W-1:0]        status,
  output logic                                lag_notice
);

  logic [ftp_pkg::PERIOD_W-1:0] target_delta_ms;
  logic                         quality_checks;
  ftp_pkg::state_t              state;
  ftp_pkg::state_t              state_next;
  ftp_pkg::result_t             result;

  logic                         req_valid;
  logic [ftp_pkg::OP_W-1:0]     req_op;
  logic [ftp_pkg::TIME_W-1:0]   req_now;
  logic                         res_load;

  // Handshake
  assign res_load = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || res_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_delta_ms <= ftp_pkg::TARGET_DELTA_RESET;
      quality_checks  <= ftp_pkg::QUALITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ftp_pkg::CFG_TARGET_DELTA: target_delta_ms <= cfg_data;
        ftp_pkg::CFG_QUALITY:      quality_checks  <= cfg_data[0];
        default:                   quality_checks  <= quality_checks;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= operation;
      req_now <= now_ms;
    end
  end

  // Step logic
  ftp_step #(
    .MAX_TICKS_PER_UPDATE(MAX_TICKS_PER_UPDATE)
  ) u_step (
    .op              (req_op),
    .now             (req_now),
    .target_delta_ms (target_delta_ms),
    .quality_checks  (quality_checks),
    .state           (state),
    .state_next      (state_next),
    .result          (result)
  );

  // Pacer state, updated as a request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (res_load) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      tick_count <= result.tick_count;
      status     <= result.status;
      lag_notice <= result.lag_notice;
    end
  end

endmodule

// ===== bench/fixed_timestep_tick_pacer_tb.sv =====
// Self-checking testbench for fixed_timestep_tick_pacer: directed and random requests
// against a built-in tick grant predictor, with random stalls on both channels.
// Depends on ftp_pkg and the fixed_timestep_tick_pacer RTL.
module fixed_timestep_tick_pacer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code the block must ignore
  localparam logic [ftp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NOTICE_EVERY = 20;
  localparam int IDLE_PCT = 28;
  localparam logic [ftp_pkg::TIME_W-1:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ftp_pkg::TIME_W-1:0] T_MIN = 64'h8000_0000_0000_0000;

  typedef enum int {NOW_HEAVY, NOW_NEAR, NOW_EARLY, NOW_WILD} now_kind_t;

  // Tracks pacer state, predicts each grant and checks results in order
  class tick_grant_board;
    logic [ftp_pkg::TIME_W-1:0]   tick_mark;
    logic [ftp_pkg::TIME_W-1:0]   advance_mark;
    logic [ftp_pkg::LAG_W-1:0]    lag_run;
    bit                           failed_flag;
    logic [ftp_pkg::PERIOD_W-1:0] period_cfg;
    bit                           checks_on;
    ftp_pkg::result_t             expected_grants[$];
    int                           mismatches;
    int                           results_seen;

    function void reset_state();
      tick_mark    = '0;
      advance_mark = '0;
      lag_run      = '0;
      failed_flag  = 1'b0;
      period_cfg   = ftp_pkg::TARGET_DELTA_RESET;
      checks_on    = ftp_pkg::QUALITY_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Applies one request to the tracked state and returns its result
    function ftp_pkg::result_t grant_ticks(logic [ftp_pkg::OP_W-1:0] op,
                                           logic [ftp_pkg::TIME_W-1:0] t);
      ftp_pkg::result_t r;
      logic [ftp_pkg::TIME_W-1:0] per, since, ahead, behind, grant;
      r = '0;
      per = (period_cfg == 0) ? 64'd1 : 64'(period_cfg);
      case (op)
        ftp_pkg::OP_START: begin
          tick_mark    = t;
          advance_mark = t;
          lag_run      = '0;
          failed_flag  = 1'b0;
        end
        ftp_pkg::OP_FAIL: failed_flag = 1'b1;
        ftp_pkg::OP_UPDATE: begin
          since = t - advance_mark;
          ahead = tick_mark - t;
          if (failed_flag) begin
            r.status = ftp_pkg::STATUS_FAILED;
          end else if (!since[ftp_pkg::TIME_W-1] && since >= per * 5 / 10 &&
                       ahead[ftp_pkg::TIME_W-1]) begin
            // one tick plus one per whole period of lag, capped
            behind = -ahead;
            grant = behind / per + 1;
            if (grant > 64'(ftp_pkg::MAX_TICKS_DEFAULT)) begin
              grant = 64'(ftp_pkg::MAX_TICKS_DEFAULT);
            end
            if (grant == 64'(ftp_pkg::MAX_TICKS_DEFAULT) && checks_on) begin
              lag_run = lag_run + 1'b1;
            end else begin
              lag_run = '0;
            end
            if (lag_run > ftp_pkg::LAG_FAIL_LIMIT) begin
              // sustained lag: marks stay as they are, the lag count still advances
              failed_flag = 1'b1;
              r.status = ftp_pkg::STATUS_FAILED_NOW;
            end else begin
              r.lag_notice = (lag_run != 0) && (int'(lag_run) % NOTICE_EVERY == 0);
              advance_mark = t;
              tick_mark = tick_mark + per * grant;
              r.tick_count = grant[ftp_pkg::TICK_W-1:0];
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(logic [ftp_pkg::OP_W-1:0] op,
                               logic [ftp_pkg::TIME_W-1:0] t);
      expected_grants.push_back(grant_ticks(op, t));
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got,
               want);
      mismatches++;
    endtask

    task check_result(logic [ftp_pkg::TICK_W-1:0] ticks,
                      logic [ftp_pkg::STATUS_W-1:0] stat, logic notice);
      ftp_pkg::result_t want;
      results_seen++;
      if (expected_grants.size() == 0) begin
        report("result with no request outstanding, tick_count", ticks, 0);
      end else begin
        want = expected_grants.pop_front();
        if (ticks !== want.tick_count) report("tick_count", ticks, want.tick_count);
        if (stat !== want.status) report("status", stat, want.status);
        if (notice !== want.lag_notice) report("lag_notice", notice, want.lag_notice);
      end
    endtask
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [ftp_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [ftp_pkg::PERIOD_W-1:0]        cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic [ftp_pkg::OP_W-1:0]            operation;
  logic signed [ftp_pkg::TIME_W-1:0]   now_ms;
  logic                                out_valid;
  logic                                out_ready;
  logic [ftp_pkg::TICK_W-1:0]          tick_count;
  logic [ftp_pkg::STATUS_W-1:0]        status;
  logic                                lag_notice;

  tick_grant_board pacer_check;
  bit calm;
  int burst_left;

  fixed_timestep_tick_pacer uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tick_count (tick_count),
    .status     (status),
    .lag_notice (lag_notice)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stalls at random except during the calm phase
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) pacer_check.note_request(operation, now_ms);
      if (out_valid && out_ready) pacer_check.check_result(tick_count, status, lag_notice);
    end
  end

  // Pick a time relative to the tracked marks so updates land where they matter
  function automatic logic [ftp_pkg::TIME_W-1:0] pick_now(now_kind_t kind);
    logic [31:0] p;
    p = (pacer_check.period_cfg == 0) ? 32'd1 : 32'(pacer_check.period_cfg);
    case (kind)
      NOW_HEAVY: return pacer_check.tick_mark + 64'(2 * p) + 64'($urandom_range(0, p));
      NOW_NEAR:  return pacer_check.tick_mark - 64'(p) + 64'($urandom_range(0, 4 * p));
      NOW_EARLY: return pacer_check.advance_mark + 64'($urandom_range(0, p));
      default:   return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ftp_pkg::TIME_W-1:0] start_time();
    return $urandom_range(0, 1) ? pick_now(NOW_WILD) : pick_now(NOW_NEAR);
  endfunction

  // Offer one request, idling first at random; returns at a falling edge
  task automatic send_req(logic [ftp_pkg::OP_W-1:0] op, logic [ftp_pkg::TIME_W-1:0] t);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    now_ms    <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off new requests until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pacer_check.pending() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(logic [ftp_pkg::CFG_IDX_W-1:0] idx,
                           logic [ftp_pkg::PERIOD_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == ftp_pkg::CFG_TARGET_DELTA) pacer_check.period_cfg = data;
    else pacer_check.checks_on = data[0];
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // One random request: mostly paced updates, some lag bursts and noise
  task automatic random_item();
    int roll;
    roll = $urandom_range(0, 99);
    if (pacer_check.failed_flag && (burst_left > 0 || roll < 30)) begin
      burst_left = 0;
      send_req(ftp_pkg::OP_START, start_time());
    end else if (burst_left > 0) begin
      burst_left--;
      send_req(ftp_pkg::OP_UPDATE, pick_now(NOW_HEAVY));
    end else if (roll < 4) begin
      send_req(ftp_pkg::OP_START, start_time());
    end else if (roll < 7) begin
      send_req(ftp_pkg::OP_FAIL, pick_now(NOW_WILD));
    end else if (roll < 8) begin
      send_req(OP_UNUSED, pick_now(NOW_WILD));
    end else if (roll < 13) begin
      send_req(ftp_pkg::OP_UPDATE, pick_now(NOW_WILD));
    end else if (roll < 22) begin
      send_req(ftp_pkg::OP_UPDATE, pick_now(NOW_EARLY));
    end else if (roll < 25) begin
      burst_left = $urandom_range(10, 36);
      send_req(ftp_pkg::OP_UPDATE, pick_now(NOW_HEAVY));
    end else if (roll < 27) begin
      wait_drained();
      send_req(ftp_pkg::OP_UPDATE, pick_now(NOW_NEAR));
    end else begin
      send_req(ftp_pkg::OP_UPDATE, pick_now(NOW_NEAR));
    end
  endtask

  task automatic run_phase(int count, int burst);
    burst_left = burst;
    send_req(ftp_pkg::OP_START, pick_now(NOW_WILD));
    for (int i = 1; i < count; i++) random_item();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = ftp_pkg::OP_START;
    now_ms     = '0;
    cfg_write  = 1'b0;
    cfg_index  = ftp_pkg::CFG_TARGET_DELTA;
    cfg_data   = '0;
    calm       = 1'b0;
    burst_left = 0;
    pacer_check = new();
    pacer_check.reset_state();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at the reset settings (16 ms period, checks on)
    send_req(ftp_pkg::OP_UPDATE, 64'd0);           // never started: mark not behind
    send_req(OP_UNUSED, T_MAX);                    // ignored code
    send_req(ftp_pkg::OP_START, T_MAX);
    send_req(ftp_pkg::OP_UPDATE, T_MAX + 64'd8);   // wraps past the top, one tick
    send_req(ftp_pkg::OP_UPDATE, T_MAX + 64'd12);  // too early
    send_req(ftp_pkg::OP_START, T_MIN);
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd3);   // too early
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd8);   // one tick
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd16);  // mark equals now
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd40);  // two ticks
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd300); // capped grant, lag counted
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd100); // time went backwards
    send_req(ftp_pkg::OP_FAIL, 64'd0);
    send_req(ftp_pkg::OP_UPDATE, T_MIN + 64'd900); // already failed
    send_req(ftp_pkg::OP_START, '1);
    send_req(ftp_pkg::OP_UPDATE, T_MAX);           // distance reads negative
    send_req(ftp_pkg::OP_UPDATE, 64'd1000);
    send_req(ftp_pkg::OP_FAIL, T_MIN);
    send_req(OP_UNUSED, 64'd0);
    send_req(ftp_pkg::OP_START, 64'd0);
    send_req(ftp_pkg::OP_UPDATE, 64'd8);

    // Random phases over several settings; the first forces a long lag run
    run_phase(90, 34);
    wait_drained();
    write_cfg(ftp_pkg::CFG_TARGET_DELTA, 16'd1);
    run_phase(80, 0);
    wait_drained();
    write_cfg(ftp_pkg::CFG_TARGET_DELTA, 16'hFFFF);
    write_cfg(ftp_pkg::CFG_QUALITY, 16'd0);
    calm = 1'b1;
    run_phase(80, 0);
    wait_drained();
    calm = 1'b0;
    write_cfg(ftp_pkg::CFG_TARGET_DELTA, 16'($urandom_range(2, 300)));
    write_cfg(ftp_pkg::CFG_QUALITY, 16'd1);
    run_phase(100, 0);
    wait_drained();
    write_cfg(ftp_pkg::CFG_TARGET_DELTA, 16'($urandom_range(1, 65535)));
    run_phase(80, 36);
    wait_drained();
    repeat (8) @(negedge clk);

    if (pacer_check.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
